// ===== hw/rtl/hsoa_pkg.sv =====
// ============================================================================
// hsoa_pkg: shared definitions for the hash set with overflow area
// Widths, operation and status codes, the control state type and the token
// that travels along the overflow cell chain.
// ============================================================================
package hsoa_pkg;

  localparam int TABLE_SIZE_DEF    = 64;
  localparam int OVERFLOW_SIZE_DEF = 8;

  localparam int KEY_W      = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int BYTE_W     = 8;
  localparam int HASH_BYTES = KEY_W / BYTE_W;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_EXISTS = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_DECIDE,
    S_CHAIN,
    S_SWEEP
  } state_t;

  // Request token handed from one overflow cell to the next.
  typedef struct packed {
    logic             act;
    logic             add;
    logic             rem;
    logic             hit;
    logic [KEY_W-1:0] key;
  } tok_t;

endpackage

// ===== hw/rtl/hsoa_cell.sv =====
// ============================================================================
// hsoa_cell: one entry of the overflow list
// Holds one key and its valid flag, serves the token passing by and hands
// the token on to the next cell through its token register.
// ============================================================================
module hsoa_cell
  import hsoa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic clr,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  tok_t             tok_r, tok_nxt;

  // The first free cell takes an added key; the first matching cell answers
  // a search, and gives up its key when the search is a removal.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tok_nxt   = tok_in;
    if (tok_in.act && !tok_in.hit) begin
      if (tok_in.add) begin
        if (!valid_r) begin
          valid_nxt   = 1'b1;
          key_nxt     = tok_in.key;
          tok_nxt.hit = 1'b1;
        end
      end else if (valid_r && (key_r == tok_in.key)) begin
        tok_nxt.hit = 1'b1;
        if (tok_in.rem) begin
          valid_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.act <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hw/rtl/hsoa_hash.sv =====
// ============================================================================
// hsoa_hash: SDBM hash and slot reduction
// Four steps fold in one key byte each, low byte first; four more steps
// reduce the hash modulo the table size, eight bits a cycle.
// ============================================================================
module hsoa_hash
  import hsoa_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [KEY_W-1:0]              key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] slot
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int STEPS  = 2 * HASH_BYTES;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
  localparam logic [SLOT_W:0]   TSIZE     = (SLOT_W + 1)'(TABLE_SIZE);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [KEY_W-1:0]    h_r, h_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [SLOT_W-1:0]   rem_r, rem_nxt;
  logic [SLOT_W-1:0]   rem_step;

  // Restoring remainder over the top byte of the hash, most significant
  // bit first.
  always_comb begin
    logic [SLOT_W:0] r;
    r = {1'b0, rem_r};
    for (int j = 0; j < BYTE_W; j++) begin
      r = {r[SLOT_W-1:0], h_r[KEY_W-1-j]};
      if (r >= TSIZE) begin
        r = r - TSIZE;
      end
    end
    rem_step = r[SLOT_W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    h_nxt    = h_r;
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      h_nxt    = '0;
      key_nxt  = key;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (step_r < STEP_W'(HASH_BYTES)) begin
        h_nxt   = {{(KEY_W - BYTE_W){1'b0}}, key_r[BYTE_W-1:0]}
                  + (h_r << 6) + (h_r << 16) - h_r;
        key_nxt = key_r >> BYTE_W;
      end else begin
        rem_nxt = rem_step;
        h_nxt   = h_r << BYTE_W;
      end
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    h_r    <= h_nxt;
    key_r  <= key_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign slot = rem_r;

endmodule

// ===== hw/rtl/hash_set_with_overflow_area.sv =====
// ============================================================================
// hash_set_with_overflow_area: set of nonzero 32-bit keys
// A direct-mapped slot memory backed by a short overflow list built as a
// chain of cells, with add, remove, exists and clear operations.
// ============================================================================
//
//   channel   ports                              handshake
//   -------   --------------------------------   -------------------------
//   input     in_op, in_key                      start high, busy low
//   result    out_status, out_entry_count        out_valid, one cycle
//
// An operation on a key passes the hash unit (four byte folds and four
// remainder steps), the registered read of the slot memory and the decide
// state before its result strobe when the direct slot settles it. When the
// overflow list must be searched or filled, the token also walks the cell
// chain. A zero key answers in the cycle after acceptance. A clear answers
// once the sweep has written every slot to empty through the single write
// port. After reset the same sweep runs with busy high and gives no result.
// The receiver cannot stall; each result is shown for one cycle only.
//
module hash_set_with_overflow_area
  import hsoa_pkg::*;
#(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int OVERFLOW_SIZE = OVERFLOW_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_entry_count
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int USED_W = $clog2(OVERFLOW_SIZE + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [USED_W-1:0] OVF_FULL  = USED_W'(OVERFLOW_SIZE);

  state_t                state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [SLOT_W-1:0]     sweep_r, sweep_nxt;
  logic                  clr_pend_r, clr_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  hash_start;
  logic                  hash_done;
  logic [SLOT_W-1:0]     slot;

  // Direct slot memory: one write port, one registered read port. The read
  // address is always the slot output of the hash unit.
  logic [KEY_W-1:0]      mem [TABLE_SIZE];
  logic [KEY_W-1:0]      rd_data_r;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_wa;
  logic [KEY_W-1:0]      mem_wd;

  logic                  chain_clr;
  tok_t                  tok_w [OVERFLOW_SIZE + 1];

  hsoa_hash #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_nxt),
    .done  (hash_done),
    .slot  (slot)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[slot];
  end

  // The overflow list. A token enters the first cell when the direct slot
  // cannot settle the operation and leaves the last cell with its answer.
  for (genvar i = 0; i < OVERFLOW_SIZE; i++) begin : g_cell
    hsoa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (chain_clr),
      .tok_in  (tok_w[i]),
      .tok_out (tok_w[i+1])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    sweep_nxt      = sweep_r;
    clr_pend_nxt   = clr_pend_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = slot;
    mem_wd         = key_r;
    hash_start     = 1'b0;
    chain_clr      = 1'b0;
    tok_w[0].act   = 1'b0;
    tok_w[0].add   = (op_r == OP_ADD);
    tok_w[0].rem   = (op_r == OP_REMOVE);
    tok_w[0].hit   = 1'b0;
    tok_w[0].key   = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_CLEAR) begin
            // Empty the chain now and sweep the slot memory before answering.
            chain_clr    = 1'b1;
            cnt_nxt      = '0;
            used_nxt     = '0;
            sweep_nxt    = '0;
            clr_pend_nxt = 1'b1;
            state_nxt    = S_SWEEP;
          end else if (in_key == '0) begin
            // The empty marker is never held, so a zero key is not found.
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
          end else begin
            op_nxt     = in_op;
            key_nxt    = in_key;
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (op_r == OP_ADD) begin
          if (rd_data_r == '0) begin
            mem_we         = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DONE;
            state_nxt      = S_IDLE;
          end else if (used_r >= OVF_FULL) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            state_nxt      = S_IDLE;
          end else begin
            tok_w[0].act = 1'b1;
            state_nxt    = S_CHAIN;
          end
        end else if (rd_data_r == key_r) begin
          // The direct slot is searched first, so it gives up its copy.
          if (op_r == OP_REMOVE) begin
            mem_we  = 1'b1;
            mem_wd  = '0;
            cnt_nxt = cnt_r - 1'b1;
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          tok_w[0].act = 1'b1;
          state_nxt    = S_CHAIN;
        end
      end

      S_CHAIN: begin
        if (tok_w[OVERFLOW_SIZE].act) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (tok_w[OVERFLOW_SIZE].hit) begin
            out_status_nxt = ST_DONE;
            if (op_r == OP_ADD) begin
              used_nxt = used_r + 1'b1;
              cnt_nxt  = cnt_r + 1'b1;
            end else if (op_r == OP_REMOVE) begin
              used_nxt = used_r - 1'b1;
              cnt_nxt  = cnt_r - 1'b1;
            end
          end else begin
            out_status_nxt = ST_MISS;
          end
        end
      end

      S_SWEEP: begin
        mem_we = 1'b1;
        mem_wa = sweep_r;
        mem_wd = '0;
        if (sweep_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
          if (clr_pend_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DONE;
            clr_pend_nxt   = 1'b0;
          end
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      clr_pend_r  <= 1'b0;
      cnt_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_pend_r  <= clr_pend_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= cnt_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== hw/rtl/hsoa_checker.sv =====
// ============================================================================
// hsoa_checker: port-level checks for the hash set with overflow area
// Watches the command and result ports and flags timing or code errors.
// ============================================================================
module hsoa_checker
  import hsoa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [OP_W-1:0]     in_op,
  input logic [KEY_W-1:0]    in_key,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [COUNT_W-1:0]  out_entry_count
);

  logic accept;
  assign accept = start && !busy;

  // The slot sweep after reset keeps the block busy.
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // A result carries a defined status code and a known key count.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_DONE || out_status == ST_MISS ||
                    out_status == ST_FULL) && !$isunknown(out_entry_count)))
    else $error("undefined status code or unknown count");

  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op != OP_CLEAR && in_key == '0)
      |=> (out_valid && out_status == ST_MISS))
    else $error("zero key not answered at once with not found");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op != OP_CLEAR && in_key != '0) |=> (busy && !out_valid))
    else $error("key operation did not start its search");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_CLEAR) |=> (busy && !out_valid))
    else $error("clear did not start its sweep");

endmodule

bind hash_set_with_overflow_area hsoa_checker u_hsoa_checker (.*);

// ===== dv/hash_set_with_overflow_area_test.sv =====
// ============================================================================
// hash_set_with_overflow_area_test: self-checking bench for the hash set
// Requests are fed from a queue through the start/busy handshake. A behavioral
// model of the slot table and overflow list predicts status and key count for
// every accepted item, and a monitor compares each result strobe against it.
// ============================================================================
module hash_set_with_overflow_area_test;
  import hsoa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE    = TABLE_SIZE_DEF;
  localparam int OVERFLOW_SIZE = OVERFLOW_SIZE_DEF;

  // Long enough for a clear sweep plus a full overflow walk, twice over.
  localparam int DRAIN_CYCLES = 2 * (TABLE_SIZE + OVERFLOW_SIZE + 12);
  localparam int CYCLE_LIMIT  = 500000;
  localparam int POOL_SIZE    = 32;
  localparam int POOL_SLOTS   = 8;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } outcome_t;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  logic [OP_W-1:0]     in_op   = OP_ADD;
  logic [KEY_W-1:0]    in_key  = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_entry_count;

  // Items waiting to be offered, and results that the model says must come.
  request_t request_q[$];
  outcome_t outcome_q[$];

  // Chance in percent that the sender holds start low in a given cycle.
  int unsigned gap_pct = 24;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Model copy of the set contents.
  logic [KEY_W-1:0] slot_mem[TABLE_SIZE];
  logic [KEY_W-1:0] spill_list[OVERFLOW_SIZE];
  int unsigned      spill_used;
  int unsigned      key_total;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  hash_set_with_overflow_area #(
    .TABLE_SIZE   (TABLE_SIZE),
    .OVERFLOW_SIZE(OVERFLOW_SIZE)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // SDBM over the four key bytes, low byte first, wrapping at 32 bits.
  function automatic int unsigned home_slot(logic [KEY_W-1:0] key);
    logic [31:0] h;
    logic [31:0] c;
    h = '0;
    for (int b = 0; b < HASH_BYTES; b++) begin
      c = 32'(key[b*BYTE_W +: BYTE_W]);
      h = c + (h << 6) + (h << 16) - h;
    end
    return h % TABLE_SIZE;
  endfunction

  function automatic void clear_set();
    foreach (slot_mem[i]) slot_mem[i] = '0;
    foreach (spill_list[i]) spill_list[i] = '0;
    spill_used = 0;
    key_total = 0;
  endfunction

  // Applies one accepted item to the model and queues the result it owes.
  function automatic void apply_to_set(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    outcome_t         res;
    int unsigned      slot;
    int               pos;
    res.status = ST_DONE;
    pos = -1;
    if (op == OP_CLEAR) begin
      clear_set();
    end else if (key == '0) begin
      // A zero key marks an empty slot, so it is never stored or found.
      res.status = ST_MISS;
    end else begin
      slot = home_slot(key);
      if (op == OP_ADD) begin
        if (slot_mem[slot] == '0) begin
          slot_mem[slot] = key;
          key_total++;
        end else if (spill_used >= OVERFLOW_SIZE) begin
          res.status = ST_FULL;
        end else begin
          spill_list[spill_used] = key;
          spill_used++;
          key_total++;
        end
      end else if (slot_mem[slot] == key) begin
        // The direct slot is searched first, so a duplicate leaves it first.
        if (op == OP_REMOVE) begin
          slot_mem[slot] = '0;
          key_total--;
        end
      end else begin
        for (int u = 0; u < spill_used; u++) begin
          if (pos < 0 && spill_list[u] == key) pos = u;
        end
        if (pos < 0) begin
          res.status = ST_MISS;
        end else if (op == OP_REMOVE) begin
          // The last overflow entry moves into the hole.
          spill_list[pos] = spill_list[spill_used-1];
          spill_list[spill_used-1] = '0;
          spill_used--;
          key_total--;
        end
      end
    end
    res.entry_count = COUNT_W'(key_total);
    outcome_q.push_back(res);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Driver. An item is taken at an edge where start is high and busy is low.
  // The model is updated at that very edge, so its order matches the block's.
  // A waiting item keeps start high; otherwise the next item is loaded unless
  // the sender decides to idle this cycle.
  always @(posedge clk) begin : drive_requests
    request_t next_req;
    logic     taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) apply_to_set(in_op, in_key);
      if (start && !taken) begin
        // Hold the offered item until the block takes it.
      end else if (request_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        next_req = request_q.pop_front();
        start  <= 1'b1;
        in_op  <= next_req.op;
        in_key <= next_req.key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Every strobe is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (status %0d count %0d)",
                                  out_status, out_entry_count));
      end else begin
        want = outcome_q.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    out_entry_count, want.entry_count));
      end
    end
  end

  // Watchdog. The limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      report_mismatch($sformatf("timeout, %0d results still expected", outcome_q.size()));
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    request_t req;
    req.op  = op;
    req.key = key;
    request_q.push_back(req);
  endtask

  // Draws random nonzero keys until one lands on the given slot.
  function automatic logic [KEY_W-1:0] key_in_slot(int unsigned slot);
    logic [KEY_W-1:0] k;
    k = $urandom;
    while (k == '0 || home_slot(k) != slot) k = $urandom;
    return k;
  endfunction

  // Random traffic. Most keys come from a pool crowded onto a few slots, so
  // the overflow list fills, overflows and gets holes punched into it. The
  // rest are fresh random keys and zero keys.
  task automatic queue_random(int unsigned n);
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    int unsigned      r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 40)      op = OP_ADD;
      else if (r < 65) op = OP_REMOVE;
      else if (r < 96) op = OP_EXISTS;
      else             op = OP_CLEAR;
      r = $urandom_range(99);
      if (r < 80)      key = key_pool[$urandom_range(POOL_SIZE-1)];
      else if (r < 96) key = $urandom;
      else             key = '0;
      queue_request(op, key);
    end
  endtask

  // Polling happens on the falling edge so that the queues and start are
  // settled when they are looked at.
  task automatic wait_requests_taken();
    while (request_q.size() != 0 || start) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] crowd[10];
    int unsigned      crowd_slot;
    clear_set();
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = key_in_slot(((i % POOL_SLOTS) * 7) % TABLE_SIZE);
    // Ten keys sharing one home slot that the all-ones key does not use.
    crowd_slot = (home_slot(32'hFFFF_FFFF) + 1) % TABLE_SIZE;
    foreach (crowd[i]) crowd[i] = key_in_slot(crowd_slot);

    // Directed part: key extremes, zero keys, a miss, a duplicate handled
    // first in its direct slot and then in the overflow list, the overflow
    // list filled to the point of rejection, a hole in its middle, and clear.
    queue_request(OP_ADD, 32'h0000_0001);
    queue_request(OP_ADD, 32'hFFFF_FFFF);
    queue_request(OP_EXISTS, 32'hFFFF_FFFF);
    queue_request(OP_ADD, '0);
    queue_request(OP_REMOVE, '0);
    queue_request(OP_EXISTS, '0);
    queue_request(OP_REMOVE, 32'h1234_5678);
    queue_request(OP_ADD, 32'h0000_0001);
    queue_request(OP_REMOVE, 32'h0000_0001);
    queue_request(OP_EXISTS, 32'h0000_0001);
    queue_request(OP_REMOVE, 32'h0000_0001);
    foreach (crowd[i]) queue_request(OP_ADD, crowd[i]);
    queue_request(OP_REMOVE, crowd[3]);
    queue_request(OP_EXISTS, crowd[8]);
    queue_request(OP_EXISTS, crowd[9]);
    queue_request(OP_CLEAR, '0);
    queue_request(OP_EXISTS, crowd[1]);

    // The block is held in reset and then runs its clearing sweep with
    // busy high; the driver simply waits that out.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 24;
    queue_random(170);
    wait_requests_taken();
    gap_pct = 47;
    queue_random(180);
    wait_requests_taken();
    gap_pct = 0;
    queue_random(180);
    wait_requests_taken();

    while (outcome_q.size() != 0) @(negedge clk);
    // Any stray strobe after the last expected one is caught by the monitor.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hsoa_pkg.sv
hw/rtl/hsoa_cell.sv
hw/rtl/hsoa_hash.sv
hw/rtl/hash_set_with_overflow_area.sv
hw/rtl/hsoa_checker.sv
dv/hash_set_with_overflow_area_test.sv
